FILE: sv/smd_pkg.sv
// ----------------------------------------------------------------------------
// smd_pkg
// Shared types and constants for the serial message deframer.
// ----------------------------------------------------------------------------
package smd_pkg;

    localparam int MAX_PAYLOAD_DEF = 32;
    localparam int CNT_W           = 8;   // payload count, up to 254
    localparam int MIN_TOTAL       = 5;   // sync, length, type, channel, checksum
    localparam int HDR_BYTES       = 4;
    localparam int FLAG_POS        = 8;   // payload byte holding the id flags
    localparam int ID_MIN_COUNT    = 13;  // payload bytes needed for an id
    localparam int OUT_DATA_W      = 72;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_LEN  = 2'd1,
        ST_SYNC = 2'd2,
        ST_SUM  = 2'd3
    } t_status;

    localparam logic CFG_SYNC = 1'b0;
    localparam logic CFG_MASK = 1'b1;

    // One classified frame, front to back
    typedef struct packed {
        t_status          status;
        logic [7:0]       msg_type;
        logic [7:0]       chan_number;
        logic [CNT_W-1:0] count;
        logic             bank;
        logic             id_present;
        logic [15:0]      device_number;
        logic [7:0]       device_kind;
        logic [7:0]       transmission_kind;
    } t_desc;

    // One result item
    typedef struct packed {
        t_status     status;
        logic [7:0]  msg_type;
        logic [7:0]  chan_number;
        logic [5:0]  payload_count;
        logic [4:0]  byte_index;
        logic [7:0]  payload_value;
        logic        payload_present;
        logic        id_present;
        logic [15:0] device_number;
        logic [7:0]  device_kind;
        logic [7:0]  transmission_kind;
        logic        run_last;
    } t_result;

    // Back tells front that a payload bank is free again
    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

endpackage

FILE: sv/smd_ram.sv
// ----------------------------------------------------------------------------
// smd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/smd_front.sv
// ----------------------------------------------------------------------------
// smd_front
// Byte intake: count, XOR, header capture, payload write, frame classify.
// ----------------------------------------------------------------------------
module smd_front #(
    parameter int MAX_PAYLOAD = smd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [7:0]                      i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [7:0]                      i_byte,
    input  logic                            i_last,
    input  logic                            i_q_full,
    output logic                            o_push,
    output smd_pkg::t_desc                  o_desc,
    input  smd_pkg::t_release               i_release,
    output logic                            o_ram_we,
    output logic [$clog2(MAX_PAYLOAD):0]    o_ram_waddr,
    output logic [7:0]                      o_ram_wdata
);
    import smd_pkg::*;

    localparam int PW = $clog2(MAX_PAYLOAD);

    logic [8:0] r_byte_count;
    logic [7:0] r_xor;
    logic       r_sync_ok;
    logic [7:0] r_len;
    logic [7:0] r_type;
    logic [7:0] r_chan;
    logic       r_ovf;
    logic [7:0] r_b8, r_b9, r_b10, r_b11, r_b12;
    logic       r_wr_bank;
    logic [1:0] r_busy;
    logic [7:0] r_sync_value;
    logic [7:0] r_ext_mask;

    logic       accept;
    logic [8:0] pos;
    logic       in_payload;
    logic       pos_fits;
    logic [CNT_W-1:0] count;
    t_desc      desc;

    assign o_ready    = !r_busy[r_wr_bank] && !i_q_full;
    assign accept     = i_valid && o_ready;
    assign pos        = r_byte_count - 9'(HDR_BYTES);
    assign in_payload = r_byte_count >= 9'(HDR_BYTES);
    assign pos_fits   = in_payload && (pos < 9'(MAX_PAYLOAD));
    assign count      = CNT_W'(pos);

    assign o_ram_we    = accept && !i_last && pos_fits;
    assign o_ram_waddr = {r_wr_bank, pos[PW-1:0]};
    assign o_ram_wdata = i_byte;

    // Classify the frame on its last byte; checks in priority order
    always_comb begin
        desc      = '0;
        desc.bank = r_wr_bank;
        if (r_byte_count < 9'(MIN_TOTAL - 1)) begin
            desc.status = ST_LEN;
        end else if (!r_sync_ok) begin
            desc.status = ST_SYNC;
        end else if (r_ovf || ({1'b0, r_len} != (r_byte_count - 9'(HDR_BYTES - 1)))) begin
            desc.status = ST_LEN;
        end else if ((r_xor ^ i_byte) != 8'd0) begin
            desc.status = ST_SUM;
        end else begin
            desc.status      = ST_OK;
            desc.msg_type    = r_type;
            desc.chan_number = r_chan;
            desc.count       = count;
            if ((count >= CNT_W'(ID_MIN_COUNT)) && ((r_b8 & r_ext_mask) != 8'd0)) begin
                desc.id_present        = 1'b1;
                desc.device_number     = {r_b10, r_b9};
                desc.device_kind       = r_b11;
                desc.transmission_kind = r_b12;
            end
        end
    end

    assign o_push = accept && i_last;
    assign o_desc = desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_xor        <= '0;
            r_sync_ok    <= 1'b0;
            r_len        <= '0;
            r_type       <= '0;
            r_chan       <= '0;
            r_ovf        <= 1'b0;
            r_wr_bank    <= 1'b0;
            r_busy       <= '0;
            r_sync_value <= 8'd164;
            r_ext_mask   <= 8'd128;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SYNC: r_sync_value <= i_cfg_data;
                    CFG_MASK: r_ext_mask   <= i_cfg_data;
                    default:  ;
                endcase
            end
            if (i_release.valid) begin
                r_busy[i_release.bank] <= 1'b0;
            end
            if (accept) begin
                if (i_last) begin
                    // hold the bank until the back drains this frame
                    r_busy[r_wr_bank] <= 1'b1;
                    r_wr_bank         <= !r_wr_bank;
                    r_byte_count      <= '0;
                    r_xor             <= '0;
                    r_sync_ok         <= 1'b0;
                    r_len             <= '0;
                    r_type            <= '0;
                    r_chan            <= '0;
                    r_ovf             <= 1'b0;
                end else begin
                    case (r_byte_count)
                        9'd0:    r_sync_ok <= (i_byte == r_sync_value);
                        9'd1:    r_len     <= i_byte;
                        9'd2:    r_type    <= i_byte;
                        9'd3:    r_chan    <= i_byte;
                        default: if (!pos_fits) r_ovf <= 1'b1;
                    endcase
                    r_xor <= r_xor ^ i_byte;
                    if (r_byte_count != 9'h1FF) begin
                        r_byte_count <= r_byte_count + 9'd1;
                    end
                end
            end
        end
    end

    // Id bytes are kept aside so the back needs no extra RAM reads
    always_ff @(posedge i_clk) begin
        if (accept && !i_last && in_payload) begin
            case (pos)
                9'(FLAG_POS):     r_b8  <= i_byte;
                9'(FLAG_POS + 1): r_b9  <= i_byte;
                9'(FLAG_POS + 2): r_b10 <= i_byte;
                9'(FLAG_POS + 3): r_b11 <= i_byte;
                9'(FLAG_POS + 4): r_b12 <= i_byte;
                default: ;
            endcase
        end
    end

endmodule

FILE: sv/smd_queue.sv
// ----------------------------------------------------------------------------
// smd_queue
// Two-entry queue of classified frames between front and back.
// ----------------------------------------------------------------------------
module smd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  smd_pkg::t_desc i_desc,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output smd_pkg::t_desc o_desc
);
    import smd_pkg::*;

    t_desc      r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_desc  = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (do_push) r_wr_ptr <= !r_wr_ptr;
            if (do_pop)  r_rd_ptr <= !r_rd_ptr;
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: ;
            endcase
        end
    end

endmodule

FILE: sv/smd_back.sv
// ----------------------------------------------------------------------------
// smd_back
// Result sequencer: pop a frame, emit an error item or the payload run.
// ----------------------------------------------------------------------------
module smd_back #(
    parameter int MAX_PAYLOAD = smd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_empty,
    input  smd_pkg::t_desc               i_desc,
    output logic                         o_pop,
    output logic [$clog2(MAX_PAYLOAD):0] o_ram_raddr,
    input  logic [7:0]                   i_ram_rdata,
    output smd_pkg::t_release            o_release,
    output logic                         o_valid,
    input  logic                         i_ready,
    output smd_pkg::t_result             o_result
);
    import smd_pkg::*;

    localparam int PW = $clog2(MAX_PAYLOAD);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_LOAD,
        S_HOLD
    } t_state;

    t_state        r_state, n_state;
    t_desc         r_desc, n_desc;
    logic [PW-1:0] r_k, n_k;
    logic          r_valid, n_valid;
    t_result       r_res, n_res;
    t_release      r_rel, n_rel;
    logic          pop;

    assign o_ram_raddr = {r_desc.bank, r_k};
    assign o_pop       = pop;
    assign o_valid     = r_valid;
    assign o_result    = r_res;
    assign o_release   = r_rel;

    always_comb begin
        n_state = r_state;
        n_desc  = r_desc;
        n_k     = r_k;
        n_valid = r_valid;
        n_res   = r_res;
        n_rel   = '0;
        pop     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    pop    = 1'b1;
                    n_desc = i_desc;
                    n_k    = '0;
                    if (i_desc.status != ST_OK || i_desc.count == '0) begin
                        // error item or empty good frame: single result
                        n_res                   = '0;
                        n_res.status            = i_desc.status;
                        n_res.msg_type          = i_desc.msg_type;
                        n_res.chan_number       = i_desc.chan_number;
                        n_res.run_last          = 1'b1;
                        n_valid                 = 1'b1;
                        n_state                 = S_HOLD;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_res.status            = r_desc.status;
                n_res.msg_type          = r_desc.msg_type;
                n_res.chan_number       = r_desc.chan_number;
                n_res.payload_count     = 6'(32'(r_desc.count));
                n_res.byte_index        = 5'(32'(r_k));
                n_res.payload_value     = i_ram_rdata;
                n_res.payload_present   = 1'b1;
                n_res.id_present        = r_desc.id_present;
                n_res.device_number     = r_desc.device_number;
                n_res.device_kind       = r_desc.device_kind;
                n_res.transmission_kind = r_desc.transmission_kind;
                n_res.run_last          = (9'(r_k) + 9'd1) >= 9'(r_desc.count);
                n_valid                 = 1'b1;
                n_state                 = S_HOLD;
            end
            S_HOLD: begin
                if (i_ready) begin
                    n_valid = 1'b0;
                    if (r_res.run_last) begin
                        n_rel.valid = 1'b1;
                        n_rel.bank  = r_desc.bank;
                        n_state     = S_IDLE;
                    end else begin
                        n_k     = r_k + PW'(1);
                        n_state = S_FETCH;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_rel   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_rel   <= n_rel;
        end
        r_desc <= n_desc;
        r_k    <= n_k;
        r_res  <= n_res;
    end

endmodule

FILE: sv/serial_message_deframer_xor_check_core.sv
// ----------------------------------------------------------------------------
// serial_message_deframer_xor_check_core
// Deframes sync/length/type/channel/payload/XOR-checksum messages.
// ----------------------------------------------------------------------------
// Bytes enter on the slave stream, one per cycle while tready is high, with
// tlast on the checksum byte. The front end writes payload bytes into one
// of two RAM banks and, on the last byte, classifies the frame (length,
// sync, length field, checksum, in that priority) and queues a descriptor.
// The back end then emits one error item, or one item per payload byte;
// each payload item passes through RAM address, registered read and output
// register, and with the single RAM read port the next byte is fetched only
// once the previous item has been taken. Because there are two banks, the
// next frame streams in while the previous one drains; the input stalls only
// when both banks hold frames not yet fully delivered. An error item carries
// only status and tlast; all other fields are zero. A good frame with no
// payload gives one item with payload_present low.
// ----------------------------------------------------------------------------
module serial_message_deframer_xor_check_core #(
    parameter int MAX_PAYLOAD = smd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: index 0 sync value, index 1 device id flag mask
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    // byte input
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // rx_byte
    input  logic        i_s_tlast,   // frame_end
    // result output
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // status[1:0], msg_type[9:2], chan_number[17:10], payload_count[23:18],
    // byte_index[28:24], payload_value[36:29], payload_present[37],
    // id_present[38], device_number[54:39], device_kind[62:55],
    // transmission_kind[70:63], zero[71]
    output logic [smd_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic        o_m_tlast    // run_last
);
    import smd_pkg::*;

    localparam int AW = $clog2(MAX_PAYLOAD) + 1;

    logic          q_full, q_empty, push, pop;
    t_desc         push_desc, head_desc;
    t_release      release_bus;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;
    t_result       res;

    // Intake and classify
    smd_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_byte      (i_s_tdata),
        .i_last      (i_s_tlast),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_desc      (push_desc),
        .i_release   (release_bus),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata)
    );

    // Payload buffer, two banks
    smd_ram #(.WIDTH(8), .DEPTH(2 ** AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Frame descriptors waiting for the back end
    smd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_desc  (head_desc)
    );

    // Emit results
    smd_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_desc      (head_desc),
        .o_pop       (pop),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_release   (release_bus),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_result    (res)
    );

    // Pack the result, first field lowest
    assign o_m_tdata = {1'b0,
                        res.transmission_kind,
                        res.device_kind,
                        res.device_number,
                        res.id_present,
                        res.payload_present,
                        res.payload_value,
                        res.byte_index,
                        res.payload_count,
                        res.chan_number,
                        res.msg_type,
                        res.status};
    assign o_m_tlast = res.run_last;

endmodule

FILE: sv/smd_checker.sv
// ----------------------------------------------------------------------------
// smd_checker
// Port-level checks on the deframer's result stream.
// ----------------------------------------------------------------------------
module smd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [smd_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic                           o_m_tlast
);
    import smd_pkg::*;

    // no result shows right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its data
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    // an error item is a run of one
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[1:0] != ST_OK) |-> o_m_tlast)
        else $error("error item without tlast");

    // an error item carries nothing but its status
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[1:0] != ST_OK) |-> (o_m_tdata[OUT_DATA_W-1:2] == '0))
        else $error("error item with nonzero fields");

endmodule

bind serial_message_deframer_xor_check_core smd_checker u_smd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the serial message deframer core.
// ----------------------------------------------------------------------------
// Frames go in byte by byte on the slave stream. A scoreboard keeps its own
// copy of the deframer state and turns every accepted byte into the result
// items it should produce. Each result item taken from the master stream is
// checked field by field against the oldest expected one. The run walks
// through several register settings. Both ends idle at random. The receiver
// also holds off once for a long stretch, so that both payload banks fill up
// and the input stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import smd_pkg::*;

    localparam int PAYLOAD_DEPTH = MAX_PAYLOAD_DEF;
    localparam int COUNT_MAX     = 511;   // byte counter saturates here
    localparam int HOLD_CYCLES   = 600;   // long receiver hold-off
    localparam int SETTLE_CYCLES = 20;    // quiet time before a register write
    localparam int TAIL_CYCLES   = 200;   // quiet time before the verdict

    typedef logic [7:0] t_frame[$];

    // ------------------------------------------------------------------------
    // Scoreboard: mirror of the deframer state plus the expected result items
    // ------------------------------------------------------------------------
    class deframer_scoreboard;
        logic [7:0]  sync_value;
        logic [7:0]  ext_mask;
        int unsigned byte_count;
        logic [7:0]  xor_sum;
        bit          sync_ok;
        logic [7:0]  length_field;
        logic [7:0]  type_hold;
        logic [7:0]  chan_hold;
        logic [7:0]  payload [PAYLOAD_DEPTH];
        bit          overflow;
        t_result     expected_results[$];
        int          errors;

        function new();
            sync_value = 8'd164;
            ext_mask   = 8'd128;
            errors     = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_count   = 0;
            xor_sum      = '0;
            sync_ok      = 1'b0;
            length_field = '0;
            type_hold    = '0;
            chan_hold    = '0;
            overflow     = 1'b0;
        endfunction

        function void push_error(t_status code);
            t_result r;
            r          = '0;
            r.status   = code;
            r.run_last = 1'b1;
            expected_results.push_back(r);
        endfunction

        // Note one accepted byte; on the frame's last byte queue its results.
        function void take_rx(logic [7:0] rx, logic frame_end);
            int unsigned total;
            int unsigned count;
            int unsigned k;
            bit          id_ok;
            t_result     r;

            if (!frame_end) begin
                case (byte_count)
                    0: sync_ok = (rx == sync_value);
                    1: length_field = rx;
                    2: type_hold = rx;
                    3: chan_hold = rx;
                    default: begin
                        if (byte_count - HDR_BYTES < PAYLOAD_DEPTH)
                            payload[byte_count - HDR_BYTES] = rx;
                        else
                            overflow = 1'b1;
                    end
                endcase
                xor_sum ^= rx;
                if (byte_count < COUNT_MAX)
                    byte_count++;
                return;
            end

            total = byte_count + 1;
            if (total < MIN_TOTAL) begin
                push_error(ST_LEN);
            end else if (!sync_ok) begin
                push_error(ST_SYNC);
            end else if (overflow || int'(length_field) != total - HDR_BYTES) begin
                push_error(ST_LEN);
            end else if ((xor_sum ^ rx) != 8'd0) begin
                push_error(ST_SUM);
            end else begin
                count = total - MIN_TOTAL;
                id_ok = (count >= ID_MIN_COUNT) && ((payload[FLAG_POS] & ext_mask) != 8'd0);
                k = 0;
                // An empty payload still gives one item, so loop at least once
                do begin
                    r                 = '0;
                    r.status          = ST_OK;
                    r.msg_type        = type_hold;
                    r.chan_number     = chan_hold;
                    r.payload_count   = 6'(count);
                    r.byte_index      = 5'(k);
                    r.payload_value   = (k < count) ? payload[k] : 8'd0;
                    r.payload_present = (k < count);
                    r.id_present      = id_ok;
                    if (id_ok) begin
                        r.device_number     = {payload[FLAG_POS+2], payload[FLAG_POS+1]};
                        r.device_kind       = payload[FLAG_POS+3];
                        r.transmission_kind = payload[FLAG_POS+4];
                    end
                    r.run_last = (k + 1 >= count);
                    expected_results.push_back(r);
                    k++;
                end while (k < count);
            end
            clear_frame();
        endfunction

        function void compare(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // Check one result item against the oldest expectation.
        function void check_result(logic [OUT_DATA_W-1:0] d, logic run_last);
            t_result want;
            if (expected_results.size() == 0) begin
                $error("result item with nothing expected: tdata %h tlast %b", d, run_last);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare("status",            want.status,            d[1:0]);
            compare("msg_type",          want.msg_type,          d[9:2]);
            compare("chan_number",       want.chan_number,       d[17:10]);
            compare("payload_count",     want.payload_count,     d[23:18]);
            compare("byte_index",        want.byte_index,        d[28:24]);
            compare("payload_value",     want.payload_value,     d[36:29]);
            compare("payload_present",   want.payload_present,   d[37]);
            compare("id_present",        want.id_present,        d[38]);
            compare("device_number",     want.device_number,     d[54:39]);
            compare("device_kind",       want.device_kind,       d[62:55]);
            compare("transmission_kind", want.transmission_kind, d[70:63]);
            compare("run_last",          want.run_last,          run_last);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block
    // ------------------------------------------------------------------------
    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic                  cfg_idx  = CFG_SYNC;
    logic [7:0]            cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    deframer_scoreboard sb;
    int  items_sent = 0;
    bit  tx_steady  = 1'b0;   // sender runs back to back while set
    bit  rx_steady  = 1'b0;   // receiver runs back to back while set
    bit  hold_req   = 1'b0;   // ask the receiver for one long hold-off

    serial_message_deframer_xor_check_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Frame builders
    // ------------------------------------------------------------------------
    function automatic t_frame add_checksum(t_frame f);
        logic [7:0] x;
        x = '0;
        foreach (f[i])
            x ^= f[i];
        f.push_back(x);
        return f;
    endfunction

    // Well-formed frame; when the payload reaches the flag byte, set or clear
    // the device id flag bits under the current mask.
    function automatic t_frame good_frame(int plen, bit flagged);
        t_frame f;
        f.push_back(sb.sync_value);
        f.push_back(8'(plen + 1));
        f.push_back(8'($urandom));
        f.push_back(8'($urandom));
        for (int k = 0; k < plen; k++)
            f.push_back(8'($urandom));
        if (plen > FLAG_POS)
            f[HDR_BYTES+FLAG_POS] = flagged ? (f[HDR_BYTES+FLAG_POS] | sb.ext_mask)
                                            : (f[HDR_BYTES+FLAG_POS] & ~sb.ext_mask);
        return add_checksum(f);
    endfunction

    // Mostly good frames with random content; the rest short, overflowing or
    // broken in sync, length or checksum (one or several at once).
    function automatic t_frame random_frame();
        t_frame     f;
        int         pick;
        int         plen;
        logic [2:0] faults;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            repeat ($urandom_range(1, 4))
                f.push_back(8'($urandom));
            return f;
        end
        if (pick < 12)
            return good_frame($urandom_range(PAYLOAD_DEPTH + 1, PAYLOAD_DEPTH + 8), 1'b1);
        plen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4)
                                           : $urandom_range(0, PAYLOAD_DEPTH);
        f = good_frame(plen, 1'($urandom_range(0, 1)));
        if (pick < 75)
            return f;
        do
            faults = 3'($urandom);
        while (faults == 3'd0);
        void'(f.pop_back());
        if (faults[0])
            f[0] ^= 8'($urandom_range(1, 255));
        if (faults[1])
            f[1] ^= 8'($urandom_range(1, 255));
        f = add_checksum(f);
        if (faults[2])
            f[f.size()-1] ^= 8'($urandom_range(1, 255));
        return f;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one byte after a random gap; return at the edge that takes it.
    task automatic send_rx(input logic [7:0] rx, input logic frame_end);
        int gap;
        if ($urandom_range(0, 31) == 0)
            tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        s_tlast  <= frame_end;
        // Sample tready mid-cycle, then the handshake lands on the next edge
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        sb.take_rx(rx, frame_end);
        items_sent++;
    endtask

    task automatic send_frame(input t_frame f);
        foreach (f[i])
            send_rx(f[i], i == f.size() - 1);
    endtask

    // Drop valid and wait until every expected item is out, then let the
    // block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers on back-to-back edges; call only while idle.
    task automatic set_regs(input logic [7:0] sync, input logic [7:0] mask);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SYNC;
        cfg_data <= sync;
        @(posedge clk);
        cfg_idx  <= CFG_MASK;
        cfg_data <= mask;
        @(posedge clk);
        cfg_we   <= 1'b0;
        sb.sync_value = sync;
        sb.ext_mask   = mask;
    endtask

    task automatic random_phase(input int budget);
        int start;
        start = items_sent;
        while (items_sent - start < budget)
            send_frame(random_frame());
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Result sink: random back-pressure, one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int                    gap;
        logic [OUT_DATA_W-1:0] d;
        logic                  l;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if ($urandom_range(0, 31) == 0)
                rx_steady = !rx_steady;
            gap = rx_steady ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(negedge clk);
            while (!m_tvalid)
                @(negedge clk);
            d = m_tdata;
            l = m_tlast;
            @(posedge clk);
            sb.check_result(d, l);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_frame     f;
        logic [7:0] s;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values, written explicitly
        set_regs(8'd164, 8'd128);
        s = sb.sync_value;

        // Directed: one-byte frame and four-byte frame (both too short)
        send_frame('{s});
        send_frame('{s, 8'h00, 8'hFF, 8'h00});
        // Good frame with empty payload, extreme header values
        send_frame(add_checksum('{s, 8'd1, 8'hFF, 8'h00}));
        // Wrong sync byte, otherwise sound
        send_frame(add_checksum('{~s, 8'd1, 8'h00, 8'hFF}));
        // Bad checksum
        f = add_checksum('{s, 8'd2, 8'h5A, 8'hA5, 8'hFF});
        f[f.size()-1] ^= 8'h01;
        send_frame(f);

        // Shortest payload that carries a device id, then a buffer overflow
        send_frame(good_frame(ID_MIN_COUNT, 1'b1));
        send_frame(good_frame(PAYLOAD_DEPTH + 1, 1'b1));
        random_phase(75);

        // Extreme registers; hold the receiver off early in this phase so the
        // banks fill while frames keep coming
        set_regs(8'h00, 8'hFF);
        send_frame(random_frame());
        hold_req = 1'b1;
        random_phase(90);

        set_regs(8'hFF, 8'h00);
        random_phase(90);

        // Random registers
        set_regs(8'($urandom), 8'($urandom));
        random_phase(90);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
